// ===== hw/rtl/ple_pkg.sv =====
// Shared types and constants for the positional list engine.
package ple_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;

    localparam int POS_W  = 8;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 5;
    localparam int WIDE_W = 64;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [CMP_W-1:0]       cmp_t;
    typedef logic [VALUE_WIDTH-1:0] word_t;
    typedef logic [WIDE_W-1:0]      wide_t;
    typedef logic [DATA_W-1:0]      data_t;
    typedef logic [LEN_W-1:0]       len_t;

    localparam cnt_t DEPTH_CNT = cnt_t'(DEPTH);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_DUMP   = 2'd2
    } op_e;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } status_e;

    // one result beat
    typedef struct packed {
        status_e status;
        data_t   entry_value;
        logic    entry_valid;
        logic    last;
        len_t    length;
    } res_t;

    // memory port request
    typedef struct packed {
        logic  we;
        idx_t  waddr;
        word_t wdata;
        logic  re;
        idx_t  raddr;
    } mem_req_t;

    // sequencer status for checks
    typedef struct packed {
        logic idle;
        cnt_t count;
    } ctrl_stat_t;

endpackage

// ===== hw/rtl/ple_mem.sv =====
// Entry storage: one write port, one registered read port.
module ple_mem (
    input  logic              clk,
    input  ple_pkg::mem_req_t req,
    output ple_pkg::word_t    rdata
);

    ple_pkg::word_t mem [ple_pkg::DEPTH];
    ple_pkg::word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/ple_ctrl.sv =====
// Sequencer: walks the shared pointer over the list for insert, remove and dump.
module ple_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic [1:0]          operation,
    input  logic [7:0]          position,
    input  logic [31:0]         value,
    output logic                res_valid,
    input  logic                res_ready,
    output ple_pkg::res_t       res,
    output ple_pkg::mem_req_t   mem_req,
    input  ple_pkg::word_t      mem_rdata,
    output ple_pkg::ctrl_stat_t stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_STEP,
        S_INS_WR,
        S_REM_STEP,
        S_REM_WR,
        S_DUMP_RD,
        S_DUMP_EMIT,
        S_RESP
    } state_t;

    state_t            state_reg;
    ple_pkg::cnt_t     ptr_reg;
    ple_pkg::cnt_t     idx_reg;
    ple_pkg::cnt_t     count_reg;
    ple_pkg::word_t    val_reg;
    ple_pkg::status_e  status_reg;

    logic              accept;
    ple_pkg::cnt_t     ptr_inc;
    ple_pkg::cnt_t     ptr_dec;
    ple_pkg::cmp_t     pos_x;
    ple_pkg::cmp_t     cnt_x;
    ple_pkg::cnt_t     ins_idx;
    logic              dump_last;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign ptr_inc    = ptr_reg + ple_pkg::cnt_t'(1);
    assign ptr_dec    = ptr_reg - ple_pkg::cnt_t'(1);
    assign pos_x      = ple_pkg::cmp_t'(position);
    assign cnt_x      = ple_pkg::cmp_t'(count_reg);
    assign dump_last  = (ptr_inc == count_reg);

    // clamp insert position into 0..count
    always_comb
    begin
        priority if (pos_x <= ple_pkg::cmp_t'(1))
            ins_idx = '0;
        else if (pos_x > cnt_x)
            ins_idx = count_reg;
        else
            ins_idx = ple_pkg::cnt_t'(pos_x - ple_pkg::cmp_t'(1));
    end

    always_comb
    begin
        mem_req = '0;
        unique case (state_reg)
            S_INS_STEP:
            begin
                if (ptr_reg == idx_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = idx_reg[ple_pkg::IDX_W-1:0];
                    mem_req.wdata = val_reg;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ptr_dec[ple_pkg::IDX_W-1:0];
                end
            end
            S_INS_WR, S_REM_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ptr_reg[ple_pkg::IDX_W-1:0];
                mem_req.wdata = mem_rdata;
            end
            S_REM_STEP:
            begin
                if (ptr_inc < count_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ptr_inc[ple_pkg::IDX_W-1:0];
                end
            end
            S_DUMP_RD:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = ptr_reg[ple_pkg::IDX_W-1:0];
            end
            default:
            begin
                mem_req = '0;
            end
        endcase
    end

    always_comb
    begin
        res.status      = status_reg;
        res.entry_value = '0;
        res.entry_valid = 1'b0;
        res.last        = 1'b1;
        res.length      = ple_pkg::len_t'(count_reg);
        if (state_reg == S_DUMP_EMIT)
        begin
            res.status      = ple_pkg::ST_OK;
            res.entry_value = ple_pkg::data_t'(ple_pkg::wide_t'(mem_rdata));
            res.entry_valid = 1'b1;
            res.last        = dump_last;
        end
    end

    assign res_valid  = (state_reg == S_DUMP_EMIT) || (state_reg == S_RESP);
    assign stat.idle  = (state_reg == S_IDLE);
    assign stat.count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ptr_reg    <= '0;
            idx_reg    <= '0;
            count_reg  <= '0;
            val_reg    <= '0;
            status_reg <= ple_pkg::ST_OK;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        val_reg    <= ple_pkg::word_t'(ple_pkg::wide_t'(value));
                        status_reg <= ple_pkg::ST_OK;
                        unique case (ple_pkg::op_e'(operation))
                            ple_pkg::OP_INSERT:
                            begin
                                if (count_reg == ple_pkg::DEPTH_CNT)
                                begin
                                    status_reg <= ple_pkg::ST_FULL;
                                    state_reg  <= S_RESP;
                                end
                                else
                                begin
                                    ptr_reg   <= count_reg;
                                    idx_reg   <= ins_idx;
                                    state_reg <= S_INS_STEP;
                                end
                            end
                            ple_pkg::OP_REMOVE:
                            begin
                                if (pos_x == '0 || pos_x > cnt_x)
                                begin
                                    status_reg <= ple_pkg::ST_BADPOS;
                                    state_reg  <= S_RESP;
                                end
                                else
                                begin
                                    ptr_reg   <= ple_pkg::cnt_t'(pos_x - ple_pkg::cmp_t'(1));
                                    state_reg <= S_REM_STEP;
                                end
                            end
                            ple_pkg::OP_DUMP:
                            begin
                                ptr_reg <= '0;
                                if (count_reg == '0)
                                    state_reg <= S_RESP;
                                else
                                    state_reg <= S_DUMP_RD;
                            end
                            default:
                            begin
                                state_reg <= S_RESP;
                            end
                        endcase
                    end
                end
                S_INS_STEP:
                begin
                    if (ptr_reg == idx_reg)
                    begin
                        count_reg <= count_reg + ple_pkg::cnt_t'(1);
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_INS_WR;
                    end
                end
                S_INS_WR:
                begin
                    ptr_reg   <= ptr_dec;
                    state_reg <= S_INS_STEP;
                end
                S_REM_STEP:
                begin
                    if (ptr_inc >= count_reg)
                    begin
                        count_reg <= count_reg - ple_pkg::cnt_t'(1);
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_REM_WR;
                    end
                end
                S_REM_WR:
                begin
                    ptr_reg   <= ptr_inc;
                    state_reg <= S_REM_STEP;
                end
                S_DUMP_RD:
                begin
                    state_reg <= S_DUMP_EMIT;
                end
                S_DUMP_EMIT:
                begin
                    if (res_ready)
                    begin
                        ptr_reg   <= ptr_inc;
                        state_reg <= dump_last ? S_IDLE : S_DUMP_RD;
                    end
                end
                S_RESP:
                begin
                    if (res_ready)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/positional_list_engine.sv =====
// Top level of the positional list engine: sequencer, entry memory, result register.
//
// Bounded ordered list addressed by 1-based position.
// Item channel (item_valid/item_ready): one beat carries operation, position, value.
//   insert puts value at clamp(position, 1, length+1); a full list answers status full.
//   remove deletes the entry at position; outside 1..length answers bad position.
//   dump sends every entry in order, last marks the final beat.
// Result channel (result_valid/result_ready): status, entry_value, entry_valid, last,
//   length. Every item ends with exactly one beat that has last set.
// Timing: one item at a time; item_ready is low from acceptance until the item's final
//   result beat moves into the output register.
//   insert moves the entries behind the slot back one at a time, remove moves the entries
//   behind the hole forward one at a time, and dump reads and then emits each entry.
//   All entry moves go through the single read port and single write port of the
//   entry memory: each move reads an entry and then writes it one slot over.
// The output register lets the sequencer finish while a result waits; a stalled receiver
//   holds the current beat and, once the register is full, stops the sequencer.
// Reset (rst_n, async low) empties the list at once; memory contents are not cleared.
module positional_list_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  position,
    input  logic [31:0] value,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  status,
    output logic [31:0] entry_value,
    output logic        entry_valid,
    output logic        last,
    output logic [4:0]  length
);

    ple_pkg::mem_req_t   mem_req;
    ple_pkg::word_t      mem_rdata;
    ple_pkg::res_t       res;
    ple_pkg::ctrl_stat_t stat;
    logic                res_valid;
    logic                res_ready;

    logic                out_valid_reg;
    ple_pkg::res_t       out_reg;

    ple_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .operation  (operation),
        .position   (position),
        .value      (value),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata),
        .stat       (stat)
    );

    ple_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // Output register: free when empty or draining this cycle.
    assign res_ready = !out_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    // Beat payload, loaded only on handoff.
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = out_reg.status;
    assign entry_value  = out_reg.entry_value;
    assign entry_valid  = out_reg.entry_valid;
    assign last         = out_reg.last;
    assign length       = out_reg.length;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.count <= ple_pkg::DEPTH_CNT)
        else $error("list count above depth");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready && !stat.idle)
        else $error("sequencer idle right after accepting an item");

    a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && entry_valid |-> status == ple_pkg::ST_OK)
        else $error("dump beat with non-ok status");

    a_idle_no_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        stat.idle |-> !res_valid)
        else $error("result offered while sequencer idle");
`endif

endmodule

// ===== tb/positional_list_checker.sv =====
// Scoreboard for the positional list engine: mirrors the list and checks every result beat.
module positional_list_checker
    import ple_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  position,
    input  logic [31:0] value,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [1:0]  status,
    input  logic [31:0] entry_value,
    input  logic        entry_valid,
    input  logic        last,
    input  logic [4:0]  length,
    output int          fail_count,
    output int          pending_results
);

    // shadow copy of the list
    word_t list_words [DEPTH];
    int    list_len = 0;
    int    errors   = 0;

    // beats still owed by the block, oldest first
    res_t  owed_beats [$];

    task automatic owe_beat(input status_e st, input data_t ev, input logic ev_valid,
                            input logic is_last);
        res_t r;
        r.status      = st;
        r.entry_value = ev;
        r.entry_valid = ev_valid;
        r.last        = is_last;
        r.length      = len_t'(list_len);
        owed_beats.push_back(r);
    endtask

    // apply one item to the shadow list and queue the beats it causes
    task automatic apply_list_op(input logic [1:0] op, input logic [7:0] pos,
                                 input logic [31:0] val);
        int slot;
        int i;
        case (op)
            OP_INSERT:
            begin
                if (list_len >= DEPTH)
                begin
                    owe_beat(ST_FULL, '0, 1'b0, 1'b1);
                end
                else
                begin
                    if (pos <= 1)
                        slot = 0;
                    else if (pos > list_len)
                        slot = list_len;
                    else
                        slot = pos - 1;
                    for (i = list_len; i > slot; i--)
                        list_words[i] = list_words[i-1];
                    list_words[slot] = word_t'(val);
                    list_len++;
                    owe_beat(ST_OK, '0, 1'b0, 1'b1);
                end
            end
            OP_REMOVE:
            begin
                if (pos < 1 || pos > list_len)
                begin
                    owe_beat(ST_BADPOS, '0, 1'b0, 1'b1);
                end
                else
                begin
                    for (i = pos - 1; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                    owe_beat(ST_OK, '0, 1'b0, 1'b1);
                end
            end
            OP_DUMP:
            begin
                if (list_len == 0)
                    owe_beat(ST_OK, '0, 1'b0, 1'b1);
                else
                    for (i = 0; i < list_len; i++)
                        owe_beat(ST_OK, data_t'(list_words[i]), 1'b1, i + 1 == list_len);
            end
            default:
            begin
                // unused code: one empty beat, list untouched
                owe_beat(ST_OK, '0, 1'b0, 1'b1);
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        res_t want;
        if (!rst_n)
        begin
            list_len = 0;
            owed_beats.delete();
            pending_results <= 0;
            fail_count      <= errors;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (owed_beats.size() == 0)
                begin
                    errors++;
                    $error("result beat with nothing expected: status %0d value %0h",
                           status, entry_value);
                end
                else
                begin
                    want = owed_beats.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("entry_value", want.entry_value, entry_value);
                    check_field("entry_valid", 32'(want.entry_valid), 32'(entry_valid));
                    check_field("last", 32'(want.last), 32'(last));
                    check_field("length", 32'(want.length), 32'(length));
                end
            end
            if (item_valid && item_ready)
                apply_list_op(operation, position, value);
            pending_results <= owed_beats.size();
            fail_count      <= errors;
        end
    end

endmodule

// ===== tb/tb_positional_list_engine.sv =====
// Top of the positional list engine testbench: clock, reset, stimulus and verdict.
module tb_positional_list_engine;
    import ple_pkg::*;

    // code outside the defined operations; the block must answer with one empty beat
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // shapes of the random traffic
    localparam int MODE_FILL  = 0;
    localparam int MODE_MIXED = 1;
    localparam int MODE_DRAIN = 2;

    localparam int RANDOM_ITEMS = 350;
    localparam int TAIL_CYCLES  = 40;   // quiet time after the last owed beat
    localparam int HOLD_CYCLES  = 250;  // long receiver hold-off
    localparam int HOLD_AFTER   = 60;   // beats seen before the hold-off starts

    // every block input gets a known value at time zero
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic [1:0]  operation    = OP_INSERT;
    logic [7:0]  position     = '0;
    logic [31:0] value        = '0;
    logic        result_ready = 1'b0;

    logic        item_ready;
    logic        result_valid;
    logic [1:0]  status;
    logic [31:0] entry_value;
    logic        entry_valid;
    logic        last;
    logic [4:0]  length;

    int fail_count;
    int pending_results;
    int beats_taken = 0;
    int burst_left  = 0;

    always #4 clk = ~clk;

    positional_list_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .operation    (operation),
        .position     (position),
        .value        (value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .entry_value  (entry_value),
        .entry_valid  (entry_valid),
        .last         (last),
        .length       (length)
    );

    positional_list_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .operation       (operation),
        .position        (position),
        .value           (value),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .status          (status),
        .entry_value     (entry_value),
        .entry_valid     (entry_valid),
        .last            (last),
        .length          (length),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // Result beats taken so far; the receiver uses it to time its long hold-off.
    always @(posedge clk)
        if (result_valid && result_ready)
            beats_taken <= beats_taken + 1;

    // Offer one item at a falling edge and hold it until a rising edge sees ready.
    // Bursts: while burst_left runs, the next item follows with valid kept high.
    // At the end of a burst valid may drop for a random gap, with junk on the payload.
    task automatic send_item(input logic [1:0] op, input logic [7:0] pos,
                             input logic [31:0] val);
        int gap;
        @(negedge clk);
        item_valid <= 1'b1;
        operation  <= op;
        position   <= pos;
        value      <= val;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap        = $urandom_range(0, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                item_valid <= 1'b0;
                operation  <= 2'($urandom);
                position   <= 8'($urandom);
                value      <= $urandom;
                repeat (gap - 1)
                    @(negedge clk);
            end
        end
    endtask

    // One random item. Fill mode leans on inserts so the list reaches full and
    // the full answer shows up; drain mode leans on removes so it empties again.
    // Positions favor the live range but also hit 0, 1, 255 and anything else.
    task automatic send_random_item(input int mode);
        int          pick;
        int          ins_cut;
        int          rem_cut;
        logic [1:0]  op;
        logic [7:0]  pos;
        logic [31:0] val;
        case (mode)
            MODE_FILL:  begin ins_cut = 80; rem_cut = 90; end
            MODE_DRAIN: begin ins_cut = 15; rem_cut = 90; end
            default:    begin ins_cut = 45; rem_cut = 90; end
        endcase
        pick = $urandom_range(0, 99);
        if (pick < ins_cut)
            op = OP_INSERT;
        else if (pick < rem_cut)
            op = OP_REMOVE;
        else if (pick < 99)
            op = OP_DUMP;
        else
            op = OP_UNUSED;

        case ($urandom_range(0, 9))
            0:       pos = 8'd0;
            1:       pos = 8'd1;
            2:       pos = 8'd255;
            3:       pos = 8'($urandom_range(0, 255));
            default: pos = 8'($urandom_range(1, 17));
        endcase

        case ($urandom_range(0, 19))
            0:       val = 32'h0000_0000;
            1:       val = 32'hFFFF_FFFF;
            default: val = $urandom;
        endcase
        send_item(op, pos, val);
    endtask

    // Stimulus: reset, a directed pass over the corner cases, then random
    // segments that cycle fill -> mixed -> drain -> mixed.
    initial
    begin : stimulus
        int items_left;
        int seg;
        int seg_len;
        int mode;
        int k;

        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;

        // empty list corners
        send_item(OP_DUMP,   8'd0,   32'h0);           // empty dump: one empty beat
        send_item(OP_REMOVE, 8'd1,   32'h0);           // nothing to remove
        send_item(OP_REMOVE, 8'd0,   32'hFFFF_FFFF);   // position zero is never valid
        send_item(OP_UNUSED, 8'd3,   32'h1234_5678);   // unused code is ignored
        // insert placement: front via 0 and 1, append via 255 and count+1, middle
        send_item(OP_INSERT, 8'd0,   32'h0000_0000);
        send_item(OP_INSERT, 8'd255, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 8'd1,   32'hA5A5_A5A5);
        send_item(OP_INSERT, 8'd2,   32'h5A5A_5A5A);
        send_item(OP_INSERT, 8'd5,   32'h0000_0001);
        send_item(OP_DUMP,   8'd0,   32'h0);
        // remove: out of range just past the end and far away, then middle, front, back
        send_item(OP_REMOVE, 8'd6,   32'h0);
        send_item(OP_REMOVE, 8'd255, 32'h0);
        send_item(OP_REMOVE, 8'd3,   32'h0);
        send_item(OP_REMOVE, 8'd1,   32'h0);
        send_item(OP_REMOVE, 8'd3,   32'h0);
        send_item(OP_DUMP,   8'd0,   32'h0);
        send_item(OP_INSERT, 8'd3,   32'h8000_0000);
        send_item(OP_INSERT, 8'd2,   32'h7FFF_FFFF);
        // drain from the front back to empty
        repeat (4)
            send_item(OP_REMOVE, 8'd1, 32'h0);
        send_item(OP_DUMP,   8'd0,   32'h0);
        send_item(OP_REMOVE, 8'd1,   32'h0);

        items_left = RANDOM_ITEMS;
        seg        = 0;
        while (items_left > 0)
        begin
            case (seg % 4)
                0:       mode = MODE_FILL;
                2:       mode = MODE_DRAIN;
                default: mode = MODE_MIXED;
            endcase
            if (mode == MODE_FILL)
                seg_len = $urandom_range(25, 40);
            else
                seg_len = $urandom_range(15, 35);
            for (k = 0; k < seg_len && items_left > 0; k++)
            begin
                send_random_item(mode);
                items_left--;
            end
            seg++;
        end

        @(negedge clk);
        item_valid <= 1'b0;

        // wait out every owed beat, then give the block time to show a stray one
        while (pending_results != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES)
            @(negedge clk);

        if (fail_count == 0 && pending_results == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: ready changes at falling edges and follows a mode that is
    // re-picked at random intervals: always ready, coin flip, or a periodic
    // pulse with a random period. Once, after enough beats, it holds off for a long stretch
    // so the output register fills and the block stops taking items.
    initial
    begin : receiver
        int  mode;
        int  mode_left;
        int  period;
        int  phase;
        bit  held;

        mode_left = 0;
        period    = 2;
        phase     = 0;
        held      = 1'b0;
        mode      = 0;
        forever
        begin
            @(negedge clk);
            if (!held && beats_taken >= HOLD_AFTER)
            begin
                held = 1'b1;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 60);
                    period    = $urandom_range(2, 6);
                    phase     = 0;
                end
                mode_left--;
                phase++;
                case (mode)
                    0:       result_ready <= 1'b1;
                    1:       result_ready <= 1'($urandom_range(0, 1));
                    default: result_ready <= (phase % period == 0);
                endcase
            end
        end
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ple_pkg.sv
hw/rtl/ple_mem.sv
hw/rtl/ple_ctrl.sv
hw/rtl/positional_list_engine.sv
tb/positional_list_checker.sv
tb/tb_positional_list_engine.sv
